// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the text console writer.
package tcw_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int ADDR_W  = 11;
   localparam int BYTE_W  = 8;
   localparam int CMD_W   = 2;

   // Character and attribute codes
   localparam logic [BYTE_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [BYTE_W-1:0] ATTR_RESET   = 8'h0F;

   // Request commands; code 3 is unused and only reports the cursor
   typedef enum logic [CMD_W-1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_PUT,
      ST_FILL,
      ST_SCROLL,
      ST_DRAIN,
      ST_READ,
      ST_RESPOND
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;      // accept a request transaction
      logic put_step;     // write one cell at the cursor and advance
      logic fill_step;    // write space/attribute at sweep index
      logic fill_reset;   // fill with the reset attribute instead of the register
      logic scroll_step;  // read source cell of sweep index for scroll
      logic read_issue;   // read the requested cell
      logic home;         // cursor to row 0, column 0
      logic respond;      // load the response register
   } ctrl_type;

   // Datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic             newline;
      logic             at_end_col;
      logic             at_last_row;
      logic             idx_last;
      logic             out_free;
   } status_type;

endpackage

// ===== hw/rtl/tcw_ctrl.sv =====
// Sequencing state machine for the text console writer.
module tcw_ctrl import tcw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            // clearing pass after reset
            ctrl.fill_step  = 1'b1;
            ctrl.fill_reset = 1'b1;
            if (status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.command)
               CMD_PUT:   state_in = ST_PUT;
               CMD_CLEAR: state_in = ST_FILL;
               CMD_READ: begin
                  ctrl.read_issue = 1'b1;
                  state_in        = ST_READ;
               end
               default:   state_in = ST_RESPOND;
            endcase
         end
         ST_PUT: begin
            ctrl.put_step = 1'b1;
            if (status.at_end_col && status.at_last_row) begin
               state_in = ST_SCROLL;
            end else if (!status.newline || status.at_end_col) begin
               state_in = ST_RESPOND;
            end
         end
         ST_FILL: begin
            ctrl.fill_step = 1'b1;
            if (status.idx_last) begin
               ctrl.home = 1'b1;
               state_in  = ST_RESPOND;
            end
         end
         ST_SCROLL: begin
            ctrl.scroll_step = 1'b1;
            if (status.idx_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last scroll write lands here
            state_in = ST_RESPOND;
         end
         ST_READ: begin
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (status.out_free) begin
               ctrl.respond = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// Cell store, cursor, sweep counter and response register of the text console writer.
module tcw_datapath import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   output status_type        status,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [BYTE_W-1:0] req_character,
   input  logic [ADDR_W-1:0] req_cell_index,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [COL_W-1:0]  rsp_cursor_column,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic              rsp_did_scroll,
   output logic [BYTE_W-1:0] rsp_read_char,
   output logic [BYTE_W-1:0] rsp_read_attribute,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BYTE_W-1:0] csr_text_attribute
);

   localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] SCROLL_LIM = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

   // Cell store: {character, attribute}
   logic [2*BYTE_W-1:0] mem [CELLS];
   logic [2*BYTE_W-1:0] rd_data_ff;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [2*BYTE_W-1:0] wr_data;

   logic [BYTE_W-1:0]   attr_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [BYTE_W-1:0]   char_ff;
   logic [ADDR_W-1:0]   index_ff;
   logic                in_range_ff;
   logic                scrolled_ff;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [ADDR_W-1:0]   idx_ff;
   logic                pend_ff;
   logic [ADDR_W-1:0]   pend_addr_ff;
   logic                pend_top_ff;

   logic                rsp_valid_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic                rsp_scroll_ff;
   logic [BYTE_W-1:0]   rsp_char_ff;
   logic [BYTE_W-1:0]   rsp_attr_ff;

   logic                at_end_col;
   logic                at_last_row;
   logic                idx_last;
   logic                is_newline;
   logic [ADDR_W-1:0]   cursor_addr;
   logic [BYTE_W-1:0]   put_char;
   logic [BYTE_W-1:0]   fill_attr;
   logic                read_hit;

   assign at_end_col  = (col_ff == LAST_COL);
   assign at_last_row = (row_ff == LAST_ROW);
   assign idx_last    = (idx_ff == LAST_IDX);
   assign is_newline  = (char_ff == NEWLINE_CODE);
   assign cursor_addr = ADDR_W'(row_ff) * ROW_STEP + ADDR_W'(col_ff);
   assign put_char    = is_newline ? SPACE_CODE : char_ff;
   assign fill_attr   = ctrl.fill_reset ? ATTR_RESET : attr_ff;

   // Attribute register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_valid) begin
         attr_ff <= csr_text_attribute;
      end
   end

   // Read port select: scroll source or requested cell
   always_comb begin
      rd_en   = ctrl.scroll_step || ctrl.read_issue;
      rd_addr = index_ff;
      if (ctrl.scroll_step) begin
         rd_addr = (idx_ff < SCROLL_LIM) ? idx_ff + ROW_STEP : idx_ff;
      end
   end

   // Write port select: pending scroll write, fill, or put
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = {SPACE_CODE, fill_attr};
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = pend_top_ff ? rd_data_ff : {SPACE_CODE, rd_data_ff[BYTE_W-1:0]};
      end else if (ctrl.fill_step) begin
         wr_en = 1'b1;
      end else if (ctrl.put_step) begin
         wr_en   = 1'b1;
         wr_addr = cursor_addr;
         wr_data = {put_char, attr_ff};
      end
   end

   // Cell store ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Scroll write pipeline: each write lands in the cycle after its read
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= ctrl.scroll_step;
      end
      pend_addr_ff <= idx_ff;
      pend_top_ff  <= (idx_ff < SCROLL_LIM);
   end

   // Sweep index, wraps to 0 after the last cell
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (ctrl.fill_step || ctrl.scroll_step) begin
         idx_ff <= idx_last ? '0 : idx_ff + 1'b1;
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff      <= req_command;
         char_ff     <= req_character;
         index_ff    <= req_cell_index;
         in_range_ff <= (req_cell_index <= LAST_IDX);
      end
   end

   // Cursor and scroll flag
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         if (ctrl.capture) begin
            scrolled_ff <= 1'b0;
         end
         if (ctrl.home) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (ctrl.put_step) begin
            if (at_end_col) begin
               col_ff <= '0;
               if (at_last_row) begin
                  scrolled_ff <= 1'b1;
               end else begin
                  row_ff <= row_ff + 1'b1;
               end
            end else begin
               col_ff <= col_ff + 1'b1;
            end
         end
      end
   end

   // Response register
   assign read_hit = (cmd_ff == CMD_READ) && in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctrl.respond) begin
         rsp_col_ff    <= col_ff;
         rsp_row_ff    <= row_ff;
         rsp_scroll_ff <= scrolled_ff && (cmd_ff == CMD_PUT);
         rsp_char_ff   <= read_hit ? rd_data_ff[2*BYTE_W-1:BYTE_W] : '0;
         rsp_attr_ff   <= read_hit ? rd_data_ff[BYTE_W-1:0] : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_column  = rsp_col_ff;
   assign rsp_cursor_row     = rsp_row_ff;
   assign rsp_did_scroll     = rsp_scroll_ff;
   assign rsp_read_char      = rsp_char_ff;
   assign rsp_read_attribute = rsp_attr_ff;

   // Status to controller
   always_comb begin
      status.command     = cmd_ff;
      status.newline     = is_newline;
      status.at_end_col  = at_end_col;
      status.at_last_row = at_last_row;
      status.idx_last    = idx_last;
      status.out_free    = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== hw/rtl/text_console_writer_core.sv =====
// Top level of the text console writer: controller plus datapath.
// 80x25 text console with one cell store (character and attribute per cell)
// behind a single write port and a registered read port. After reset the block
// runs a clearing pass (one cell per cycle) with req_stall high; attribute
// writes on the csr channel are taken meanwhile. A printable character or
// read goes through decode and its put or read state to the response
// register. A newline fills the rest of its row with spaces (up to 80 cells).
// A clear walks the whole store. A put or newline that runs off the last row
// adds a scroll sweep, copying one cell per cycle through the store's read
// and write ports. One transaction is worked on at a time; a new one can be
// accepted while the previous response still waits on rsp_stall.
module text_console_writer_core import tcw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [BYTE_W-1:0] req_character,
   input  logic [ADDR_W-1:0] req_cell_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [COL_W-1:0]  rsp_cursor_column,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic              rsp_did_scroll,
   output logic [BYTE_W-1:0] rsp_read_char,
   output logic [BYTE_W-1:0] rsp_read_attribute,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BYTE_W-1:0] csr_text_attribute
);

   ctrl_type   ctrl;
   status_type status;

   // Sequencer
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Store, cursor and response
   tcw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .req_command        (req_command),
      .req_character      (req_character),
      .req_cell_index     (req_cell_index),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_did_scroll     (rsp_did_scroll),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_attribute (rsp_read_attribute),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

endmodule
